[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, sampled on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

[design/mfs_pkg.sv]
// ----------------------------------------------------------------------------
// mfs_pkg
// Types and constants of the magnetometer frame smoother.
// ----------------------------------------------------------------------------
package mfs_pkg;

    typedef logic signed [22:0] field_t;
    typedef logic        [15:0] heading_t;
    typedef logic        [22:0] magnitude_t;
    typedef logic signed [16:0] temp_t;
    typedef logic signed [26:0] angle_t;

    localparam logic [2:0]  REG_SMOOTHING_ADDR = 3'd0;
    localparam logic [8:0]  WEIGHT_FULL        = 9'd256;
    localparam int          UT16_PER_COUNT     = 1568;
    localparam logic [11:0] TEMP_OFFSET        = 12'd349;
    // ceil(2^24 / 11); exact quotient for any 20-bit numerator
    localparam logic [20:0] TEMP_RECIP         = 21'd1525202;
    localparam logic [19:0] TEMP_ROUND         = 20'd5;
    localparam angle_t      DEG_FULL           = 27'sd23592960;
    localparam angle_t      HALF_TURN          = 27'sd11796480;
    localparam logic [16:0] HEADING_WRAP       = 17'd46080;
    localparam int          ATAN_DEPTH         = 24;

    // atan(2^-i) in 1/65536 degree
    function automatic angle_t atan_entry(input logic [4:0] idx);
        angle_t v;
        case (idx)
            5'd0:    v = 27'sd2949120;
            5'd1:    v = 27'sd1740967;
            5'd2:    v = 27'sd919879;
            5'd3:    v = 27'sd466945;
            5'd4:    v = 27'sd234379;
            5'd5:    v = 27'sd117304;
            5'd6:    v = 27'sd58666;
            5'd7:    v = 27'sd29335;
            5'd8:    v = 27'sd14668;
            5'd9:    v = 27'sd7334;
            5'd10:   v = 27'sd3667;
            5'd11:   v = 27'sd1833;
            5'd12:   v = 27'sd917;
            5'd13:   v = 27'sd458;
            5'd14:   v = 27'sd229;
            5'd15:   v = 27'sd115;
            5'd16:   v = 27'sd57;
            5'd17:   v = 27'sd29;
            5'd18:   v = 27'sd14;
            5'd19:   v = 27'sd7;
            5'd20:   v = 27'sd4;
            5'd21:   v = 27'sd2;
            5'd22:   v = 27'sd1;
            default: v = 27'sd0;
        endcase
        return v;
    endfunction

endpackage

[design/mfs_if.sv]
// ----------------------------------------------------------------------------
// mfs_if
// Valid/ready channels for sensor frames and smoothed results.
// ----------------------------------------------------------------------------
interface mfs_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] x_high_byte;
    logic [7:0] y_high_byte;
    logic [7:0] z_high_byte;
    logic [7:0] temp_frame_byte;
    logic [7:0] xy_low_byte;
    logic [7:0] z_low_byte;
    logic [7:0] temp_low_byte;

    modport source (output valid, x_high_byte, y_high_byte, z_high_byte, temp_frame_byte,
                    xy_low_byte, z_low_byte, temp_low_byte, input ready);
    modport sink   (input valid, x_high_byte, y_high_byte, z_high_byte, temp_frame_byte,
                    xy_low_byte, z_low_byte, temp_low_byte, output ready);
endinterface

interface mfs_result_if;
    logic                   valid;
    logic                   ready;
    mfs_pkg::field_t        field_x;
    mfs_pkg::field_t        field_y;
    mfs_pkg::field_t        field_z;
    mfs_pkg::heading_t      heading;
    mfs_pkg::magnitude_t    magnitude;
    mfs_pkg::temp_t         temperature;

    modport source (output valid, field_x, field_y, field_z, heading, magnitude, temperature,
                    input ready);
    modport sink   (input valid, field_x, field_y, field_z, heading, magnitude, temperature,
                    output ready);
endinterface

[design/magnetometer_frame_smoother_top.sv]
// ----------------------------------------------------------------------------
// magnetometer_frame_smoother_top
// Frame filter, EMA smoothing, CORDIC heading, magnitude and temperature.
// ----------------------------------------------------------------------------
// One frame is taken only while the block is idle. A frame whose counter equals
// the last accepted one is dropped in its accept cycle. Otherwise the frame runs
// through one shared 24x24 multiplier (scale, weight unless seeding, square per
// axis), then CORDIC_STEPS micro-rotations of the shift/add CORDIC unit, a wrap
// state (the temperature reciprocal multiply shares it), a bit-serial square
// root and a load of the output register. A new frame may be accepted while
// the last result still waits in the output register.
module magnetometer_frame_smoother_top #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    mfs_frame_if.sink             frame,
    mfs_result_if.source          result
);
    import mfs_pkg::*;

    localparam int STEP_W = $clog2(CORDIC_STEPS);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SCALE  = 4'd1;
    localparam logic [3:0] ST_DIFF   = 4'd2;
    localparam logic [3:0] ST_WMUL   = 4'd3;
    localparam logic [3:0] ST_WADD   = 4'd4;
    localparam logic [3:0] ST_SQMUL  = 4'd5;
    localparam logic [3:0] ST_SQADD  = 4'd6;
    localparam logic [3:0] ST_CORDIC = 4'd7;
    localparam logic [3:0] ST_WRAP   = 4'd8;
    localparam logic [3:0] ST_SQRT   = 4'd9;
    localparam logic [3:0] ST_DONE   = 4'd10;

    localparam logic [1:0] AX_LAST     = 2'd2;
    localparam logic [4:0] SQRT_LAST   = 5'd22;

    logic [3:0]          state_reg;
    logic [1:0]          ax_reg;
    logic [8:0]          weight_reg;
    logic [1:0]          last_counter_reg;
    logic                counter_seen_reg;
    logic                avg_started_reg;
    logic                seed_reg;
    logic [8:0]          w_eff_reg;
    logic                out_valid_reg;

    logic [11:0]         raw_reg [3];
    field_t              avg_reg [3];
    logic signed [47:0]  prod_reg;
    logic signed [23:0]  diff_reg;
    logic [44:0]         acc_reg;
    logic signed [42:0]  cx_reg;
    logic signed [42:0]  cy_reg;
    angle_t              cz_reg;
    logic                zero_hdg_reg;
    logic [STEP_W-1:0]   cordic_cnt_reg;
    heading_t            hdg_reg;
    logic [44:0]         sq_v_reg;
    logic [44:0]         sq_r_reg;
    logic [44:0]         sq_bit_reg;
    logic [4:0]          sq_cnt_reg;
    logic [19:0]         tnum_reg;
    logic [19:0]         tq_reg;
    logic                tneg_reg;

    field_t              out_x_reg;
    field_t              out_y_reg;
    field_t              out_z_reg;
    heading_t            out_hdg_reg;
    magnitude_t          out_mag_reg;
    temp_t               out_temp_reg;

    // request decode
    logic       in_fire;
    logic [1:0] frm_cnt;
    logic       stale;
    logic       cfg_wr;
    logic [8:0] w_sat;
    logic       out_load;

    assign frame.ready = (state_reg == ST_IDLE);
    assign in_fire     = frame.valid && frame.ready;
    assign frm_cnt     = frame.temp_frame_byte[3:2];
    assign stale       = counter_seen_reg && (frm_cnt == last_counter_reg);
    assign w_sat       = (weight_reg > WEIGHT_FULL) ? WEIGHT_FULL : weight_reg;
    assign out_load    = (state_reg == ST_DONE) && (!out_valid_reg || result.ready);

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == REG_SMOOTHING_ADDR);
    assign prdata = (paddr == REG_SMOOTHING_ADDR) ? {23'd0, weight_reg} : 32'd0;

    // temperature numerator at accept: |(raw-349)*160| + 5
    logic signed [20:0] t_off;
    logic signed [20:0] t_scaled;
    logic [20:0]        t_abs;

    always_comb
    begin
        t_off    = signed'(21'({frame.temp_frame_byte[7:4], frame.temp_low_byte}))
                 - signed'(21'(TEMP_OFFSET));
        t_scaled = (t_off <<< 7) + (t_off <<< 5);
        t_abs    = t_scaled[20] ? 21'(-t_scaled) : t_scaled;
    end

    // shared multiplier
    logic [11:0]        raw_sel;
    field_t             avg_sel;
    logic signed [23:0] mul_a;
    logic signed [23:0] mul_b;
    logic signed [47:0] mul_p;

    assign raw_sel = raw_reg[ax_reg];
    assign avg_sel = avg_reg[ax_reg];

    always_comb
    begin
        case (state_reg)
            ST_SCALE:
            begin
                mul_a = {{12{raw_sel[11]}}, raw_sel};
                mul_b = 24'(UT16_PER_COUNT);
            end
            ST_WMUL:
            begin
                mul_a = diff_reg;
                mul_b = signed'({15'd0, w_eff_reg});
            end
            ST_WRAP:
            begin
                // divide by 11 as a multiply by the scaled reciprocal
                mul_a = signed'({4'd0, tnum_reg});
                mul_b = signed'({3'd0, TEMP_RECIP});
            end
            default:
            begin
                mul_a = {avg_sel[22], avg_sel};
                mul_b = {avg_sel[22], avg_sel};
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // CORDIC micro-rotation
    logic signed [42:0] xs;
    logic signed [42:0] ys;
    logic signed [42:0] x0;
    logic signed [42:0] y0;
    angle_t             z_wrap;
    logic [16:0]        h_raw;

    always_comb
    begin
        xs     = cx_reg >>> cordic_cnt_reg;
        ys     = cy_reg >>> cordic_cnt_reg;
        x0     = {{4{avg_reg[0][22]}}, avg_reg[0], 16'd0};
        y0     = {{4{avg_reg[1][22]}}, avg_reg[1], 16'd0};
        if (cz_reg < 0)
        begin
            z_wrap = cz_reg + DEG_FULL;
        end
        else if (cz_reg >= DEG_FULL)
        begin
            z_wrap = cz_reg - DEG_FULL;
        end
        else
        begin
            z_wrap = cz_reg;
        end
        h_raw = 17'((z_wrap + 27'sd256) >>> 9);
    end

    // square root step and EMA increment
    logic [44:0] sq_trial;
    logic signed [23:0] ema_inc;

    assign sq_trial = sq_r_reg + sq_bit_reg;
    assign ema_inc  = 24'((prod_reg + 48'sd128) >>> 8);

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            ax_reg           <= 2'd0;
            weight_reg       <= 9'd0;
            last_counter_reg <= 2'd0;
            counter_seen_reg <= 1'b0;
            avg_started_reg  <= 1'b0;
            out_valid_reg    <= 1'b0;
            cordic_cnt_reg   <= '0;
            sq_cnt_reg       <= 5'd0;
        end
        else
        begin
            if (cfg_wr)
            begin
                weight_reg <= pwdata[8:0];
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire && !stale)
                    begin
                        counter_seen_reg <= 1'b1;
                        last_counter_reg <= frm_cnt;
                        ax_reg           <= 2'd0;
                        state_reg        <= ST_SCALE;
                    end
                end
                ST_SCALE:
                begin
                    state_reg <= ST_DIFF;
                end
                ST_DIFF:
                begin
                    if (seed_reg)
                    begin
                        if (ax_reg == AX_LAST)
                        begin
                            ax_reg    <= 2'd0;
                            state_reg <= ST_SQMUL;
                        end
                        else
                        begin
                            ax_reg    <= ax_reg + 2'd1;
                            state_reg <= ST_SCALE;
                        end
                    end
                    else
                    begin
                        state_reg <= ST_WMUL;
                    end
                end
                ST_WMUL:
                begin
                    state_reg <= ST_WADD;
                end
                ST_WADD:
                begin
                    if (ax_reg == AX_LAST)
                    begin
                        ax_reg    <= 2'd0;
                        state_reg <= ST_SQMUL;
                    end
                    else
                    begin
                        ax_reg    <= ax_reg + 2'd1;
                        state_reg <= ST_SCALE;
                    end
                end
                ST_SQMUL:
                begin
                    avg_started_reg <= 1'b1;
                    state_reg       <= ST_SQADD;
                end
                ST_SQADD:
                begin
                    if (ax_reg == AX_LAST)
                    begin
                        ax_reg         <= 2'd0;
                        cordic_cnt_reg <= '0;
                        state_reg      <= ST_CORDIC;
                    end
                    else
                    begin
                        ax_reg    <= ax_reg + 2'd1;
                        state_reg <= ST_SQMUL;
                    end
                end
                ST_CORDIC:
                begin
                    cordic_cnt_reg <= cordic_cnt_reg + 1'b1;
                    if (cordic_cnt_reg == STEP_W'(CORDIC_STEPS - 1))
                    begin
                        state_reg <= ST_WRAP;
                    end
                end
                ST_WRAP:
                begin
                    sq_cnt_reg <= 5'd0;
                    state_reg  <= ST_SQRT;
                end
                ST_SQRT:
                begin
                    sq_cnt_reg <= sq_cnt_reg + 5'd1;
                    if (sq_cnt_reg == SQRT_LAST)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                raw_reg[0] <= {frame.x_high_byte, frame.xy_low_byte[7:4]};
                raw_reg[1] <= {frame.y_high_byte, frame.xy_low_byte[3:0]};
                raw_reg[2] <= {frame.z_high_byte, frame.z_low_byte[3:0]};
                seed_reg   <= (w_sat == 9'd0) || !avg_started_reg;
                w_eff_reg  <= w_sat;
                acc_reg    <= 45'd0;
                tneg_reg   <= t_scaled[20];
                tnum_reg   <= t_abs[19:0] + TEMP_ROUND;
            end
            ST_SCALE, ST_WMUL, ST_SQMUL:
            begin
                prod_reg <= mul_p;
            end
            ST_DIFF:
            begin
                if (seed_reg)
                begin
                    avg_reg[ax_reg] <= prod_reg[22:0];
                end
                else
                begin
                    diff_reg <= {prod_reg[22], prod_reg[22:0]} - {avg_sel[22], avg_sel};
                end
            end
            ST_WADD:
            begin
                avg_reg[ax_reg] <= 23'({avg_sel[22], avg_sel} + ema_inc);
            end
            ST_SQADD:
            begin
                acc_reg <= acc_reg + prod_reg[44:0];
                if (ax_reg == AX_LAST)
                begin
                    zero_hdg_reg <= (avg_reg[0] == '0) && (avg_reg[1] == '0);
                    if (avg_reg[0][22])
                    begin
                        cx_reg <= -x0;
                        cy_reg <= -y0;
                        cz_reg <= HALF_TURN;
                    end
                    else
                    begin
                        cx_reg <= x0;
                        cy_reg <= y0;
                        cz_reg <= '0;
                    end
                end
            end
            ST_CORDIC:
            begin
                if (cy_reg > 0)
                begin
                    cx_reg <= cx_reg + ys;
                    cy_reg <= cy_reg - xs;
                    cz_reg <= cz_reg + atan_entry(5'(cordic_cnt_reg));
                end
                else
                begin
                    cx_reg <= cx_reg - ys;
                    cy_reg <= cy_reg + xs;
                    cz_reg <= cz_reg - atan_entry(5'(cordic_cnt_reg));
                end
            end
            ST_WRAP:
            begin
                if (zero_hdg_reg || (h_raw >= HEADING_WRAP))
                begin
                    hdg_reg <= '0;
                end
                else
                begin
                    hdg_reg <= h_raw[15:0];
                end
                sq_v_reg   <= acc_reg;
                sq_r_reg   <= 45'd0;
                sq_bit_reg <= 45'd1 << 44;
                tq_reg     <= mul_p[43:24];
            end
            ST_SQRT:
            begin
                if (sq_v_reg >= sq_trial)
                begin
                    sq_v_reg <= sq_v_reg - sq_trial;
                    sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
                end
                else
                begin
                    sq_r_reg <= sq_r_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_x_reg    <= avg_reg[0];
                    out_y_reg    <= avg_reg[1];
                    out_z_reg    <= avg_reg[2];
                    out_hdg_reg  <= hdg_reg;
                    out_mag_reg  <= 23'(sq_r_reg + {44'd0, (sq_v_reg > sq_r_reg)});
                    out_temp_reg <= tneg_reg ? 17'(-signed'({1'b0, tq_reg}))
                                             : 17'(tq_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign result.valid       = out_valid_reg;
    assign result.field_x     = out_x_reg;
    assign result.field_y     = out_y_reg;
    assign result.field_z     = out_z_reg;
    assign result.heading     = out_hdg_reg;
    assign result.magnitude   = out_mag_reg;
    assign result.temperature = out_temp_reg;

`include "assert_macros.svh"

    `ASSERT_NEXT(a_stale_dropped, in_fire && stale, (state_reg == ST_IDLE) && $stable(last_counter_reg))
    `ASSERT_IMPLIES(a_cordic_seeded, state_reg == ST_CORDIC, avg_started_reg && counter_seen_reg)
    `ASSERT_IMPLIES(a_heading_range, state_reg == ST_DONE, hdg_reg < HEADING_WRAP[15:0])

endmodule
